>>> hw/rtl/rbrs_pkg.sv
// shared types and constants of the retry backoff request sequencer
package rbrs_pkg;

	localparam int TIME_BITS_DEF    = 48;
	localparam int BACKOFF_BITS_DEF = 32;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [10:0] RST_MAX_ATTEMPTS = 11'd3;
	localparam logic [31:0] RST_INIT_BACKOFF = 32'd100;
	localparam logic [31:0] RST_MAX_BACKOFF  = 32'd10000;
	localparam logic [15:0] RST_TARGET_NODE  = 16'd1;

	// status codes, same encoding on input and output
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_UNAVAILABLE = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED   = 3'd2;
	localparam logic [2:0] ST_IO_ERROR    = 3'd3;
	localparam logic [2:0] ST_OTHER       = 3'd4;
	localparam logic [2:0] ST_NONE        = 3'd5;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_FAIL  = 2'd1,
		OP_RESP  = 2'd2,
		OP_NONE  = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		OC_ACCEPTED   = 3'd0,
		OC_TERMINAL   = 3'd1,
		OC_PENDING    = 3'd2,
		OC_BACKOFF    = 3'd3,
		OC_BUDGET     = 3'd4,
		OC_NO_ATTEMPT = 3'd5,
		OC_OK_NO_FAIL = 3'd6
	} outcome_e;

	// classified request as it leaves the front
	typedef struct packed {
		op_e        op;
		logic [2:0] code;
		logic       retry;
	} cls_t;

	// result without the deadline, which is carried next to it
	typedef struct packed {
		outcome_e    outcome;
		logic [2:0]  phase;
		logic [10:0] attempt;
		logic [15:0] target;
		logic        dl_valid;
		logic [2:0]  status;
	} res_t;

endpackage

>>> hw/rtl/retry_backoff_request_sequencer.sv
// top level: configuration registers, front, request queue, back and result queue
//
// Retry sequencer for one request with capped exponential backoff.
// Requests (opcode, now_ms, status) enter through push/full: a request
// is taken at an edge with push high and full low. Results leave through
// empty/pop: the oldest result sits on the result ports while empty is low
// and is taken at an edge with pop high. Each request gives one result.
// A request is decoded into the request queue, carried out by the back when it
// leaves that queue, and its result reaches the ports through the result queue;
// one request per cycle sustained while the result queue is not full, as the
// back updates its state in one step (one add, compares and a shift).
// When the receiver stops popping, the two-entry result queue fills, the
// back holds, the two-entry request queue fills and full rises.
// Reset empties both queues, puts the sequencer in idle with no attempts, no
// deadline and no recorded status, and loads the register reset values. Byte
// addresses 0 (max_attempts), 4 (initial_backoff_ms), 8 (max_backoff_ms), 12
// (target_node) hold the registers; the user writes only while idle, unchecked.
module retry_backoff_request_sequencer #(
	parameter int TIME_BITS    = rbrs_pkg::TIME_BITS_DEF,
	parameter int BACKOFF_BITS = rbrs_pkg::BACKOFF_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           opcode,
	input  logic [TIME_BITS-1:0] now_ms,
	input  logic [2:0]           status,
	output logic                 empty,
	input  logic                 pop,
	output logic [2:0]           outcome,
	output logic [2:0]           phase,
	output logic [10:0]          attempt_number,
	output logic [15:0]          attempt_target,
	output logic                 deadline_valid,
	output logic [TIME_BITS-1:0] retry_deadline_ms,
	output logic [2:0]           recorded_status
);
	import rbrs_pkg::*;

	localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd0;
	localparam logic [1:0] REG_INIT_BACKOFF = 2'd1;
	localparam logic [1:0] REG_MAX_BACKOFF  = 2'd2;
	localparam logic [1:0] REG_TARGET_NODE  = 2'd3;

	localparam int REQ_WIDTH = $bits(cls_t) + TIME_BITS;
	localparam int RES_WIDTH = $bits(res_t) + TIME_BITS;

	logic [10:0]             max_attempts_q;
	logic [BACKOFF_BITS-1:0] init_backoff_q;
	logic [BACKOFF_BITS-1:0] max_backoff_q;
	logic [15:0]             target_node_q;
	logic                    cfg_wr;
	logic                    init_wr;

	cls_t                    in_cls;
	cls_t                    req_cls;
	logic [REQ_WIDTH-1:0]    req_rdata;
	logic [TIME_BITS-1:0]    req_now;
	logic                    req_empty;
	logic                    req_take;

	res_t                    res;
	res_t                    res_out;
	logic [TIME_BITS-1:0]    res_deadline;
	logic [RES_WIDTH-1:0]    res_rdata;
	logic                    res_full;
	logic                    res_push;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign init_wr = cfg_wr && (paddr[3:2] == REG_INIT_BACKOFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q <= RST_MAX_ATTEMPTS;
			init_backoff_q <= BACKOFF_BITS'(RST_INIT_BACKOFF);
			max_backoff_q  <= BACKOFF_BITS'(RST_MAX_BACKOFF);
			target_node_q  <= RST_TARGET_NODE;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MAX_ATTEMPTS: max_attempts_q <= pwdata[10:0];
				REG_INIT_BACKOFF: init_backoff_q <= BACKOFF_BITS'(pwdata);
				REG_MAX_BACKOFF:  max_backoff_q  <= BACKOFF_BITS'(pwdata);
				REG_TARGET_NODE:  target_node_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_ATTEMPTS: prdata = 32'(max_attempts_q);
			REG_INIT_BACKOFF: prdata = 32'(init_backoff_q);
			REG_MAX_BACKOFF:  prdata = 32'(max_backoff_q);
			REG_TARGET_NODE:  prdata = 32'(target_node_q);
			default:          prdata = '0;
		endcase
	end

	rbrs_front u_front (
		.opcode (opcode),
		.status (status),
		.cls    (in_cls)
	);

	rbrs_fifo #(
		.WIDTH (REQ_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_req_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({in_cls, now_ms}),
		.full   (full),
		.pop    (req_take),
		.rdata  (req_rdata),
		.empty  (req_empty)
	);

	assign req_cls = cls_t'(req_rdata[REQ_WIDTH-1:TIME_BITS]);
	assign req_now = req_rdata[TIME_BITS-1:0];

	// the backoff reload takes the value being written, not the old register
	rbrs_back #(
		.TIME_BITS    (TIME_BITS),
		.BACKOFF_BITS (BACKOFF_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_attempts (max_attempts_q),
		.init_backoff (BACKOFF_BITS'(pwdata)),
		.max_backoff  (max_backoff_q),
		.target_node  (target_node_q),
		.init_wr      (init_wr),
		.req_valid    (!req_empty),
		.req_cls      (req_cls),
		.req_now      (req_now),
		.req_take     (req_take),
		.res_full     (res_full),
		.res_push     (res_push),
		.res          (res),
		.res_deadline (res_deadline)
	);

	rbrs_fifo #(
		.WIDTH (RES_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res, res_deadline}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out           = res_t'(res_rdata[RES_WIDTH-1:TIME_BITS]);
	assign outcome           = res_out.outcome;
	assign phase             = res_out.phase;
	assign attempt_number    = res_out.attempt;
	assign attempt_target    = res_out.target;
	assign deadline_valid    = res_out.dl_valid;
	assign recorded_status   = res_out.status;
	assign retry_deadline_ms = res_rdata[TIME_BITS-1:0];

endmodule

>>> hw/rtl/rbrs_fifo.sv
// small first-in first-out queue used between the parts of the sequencer
module rbrs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> (count_q == CNT_BITS'(DEPTH)) || $past(do_pop))
		else $error("queue count moved past its depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone push");
	a_ptrs_meet_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers differ while empty");
`endif

endmodule

>>> hw/rtl/rbrs_front.sv
// front: decodes the opcode and classifies the status of each request
module rbrs_front (
	input  logic [1:0]          opcode,
	input  logic [2:0]          status,
	output rbrs_pkg::cls_t      cls
);
	import rbrs_pkg::*;

	logic [2:0] code;

	// unknown status codes count as other failure
	assign code = (status > ST_OTHER) ? ST_OTHER : status;

	always_comb begin
		cls.code  = code;
		cls.retry = (code == ST_UNAVAILABLE) || (code == ST_EXHAUSTED) || (code == ST_IO_ERROR);
		unique case (opcode)
			2'd0:    cls.op = OP_BEGIN;
			2'd1:    cls.op = OP_FAIL;
			2'd2:    cls.op = OP_RESP;
			default: cls.op = OP_NONE;
		endcase
	end

endmodule

>>> hw/rtl/rbrs_back.sv
// back: phase state machine, attempt budget and backoff deadline
module rbrs_back #(
	parameter int TIME_BITS    = rbrs_pkg::TIME_BITS_DEF,
	parameter int BACKOFF_BITS = rbrs_pkg::BACKOFF_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [10:0]             max_attempts,
	input  logic [BACKOFF_BITS-1:0] init_backoff,
	input  logic [BACKOFF_BITS-1:0] max_backoff,
	input  logic [15:0]             target_node,
	input  logic                    init_wr,
	input  logic                    req_valid,
	input  rbrs_pkg::cls_t          req_cls,
	input  logic [TIME_BITS-1:0]    req_now,
	output logic                    req_take,
	input  logic                    res_full,
	output logic                    res_push,
	output rbrs_pkg::res_t          res,
	output logic [TIME_BITS-1:0]    res_deadline
);
	import rbrs_pkg::*;

	localparam int SUM_BITS = ((TIME_BITS > BACKOFF_BITS) ? TIME_BITS : BACKOFF_BITS) + 1;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WAIT    = 3'd1,
		PH_BACKOFF = 3'd2,
		PH_DONE    = 3'd3,
		PH_FAIL    = 3'd4
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [10:0]             cnt_q, cnt_d;
	logic [BACKOFF_BITS-1:0] bo_q, bo_d;
	logic [TIME_BITS-1:0]    dl_q, dl_d;
	logic                    dl_set_q, dl_set_d;
	logic [2:0]              status_q, status_d;
	outcome_e                outcome;
	logic                    accepted;

	logic [SUM_BITS-1:0]     sum;
	logic [TIME_BITS-1:0]    dl_sat;
	logic [BACKOFF_BITS:0]   twice;
	logic [BACKOFF_BITS-1:0] bo_next;
	logic                    budget_out;

	assign req_take = req_valid && !res_full;
	assign res_push = req_take;

	assign sum    = SUM_BITS'(req_now) + SUM_BITS'(bo_q);
	assign dl_sat = (sum > SUM_BITS'({TIME_BITS{1'b1}})) ? '1 : TIME_BITS'(sum);
	assign twice  = {bo_q, 1'b0};
	// doubles up to the cap, stays put once at or above it
	assign bo_next = (bo_q >= max_backoff) ? bo_q :
		(twice > {1'b0, max_backoff}) ? max_backoff : BACKOFF_BITS'(twice);
	assign budget_out = (cnt_q >= max_attempts);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		bo_d     = bo_q;
		dl_d     = dl_q;
		dl_set_d = dl_set_q;
		status_d = status_q;
		outcome  = OC_ACCEPTED;
		accepted = 1'b0;
		unique case (req_cls.op)
			OP_BEGIN: begin
				priority if (phase_q == PH_DONE || phase_q == PH_FAIL) begin
					outcome = OC_TERMINAL;
				end else if (phase_q == PH_WAIT) begin
					outcome = OC_PENDING;
				end else if (phase_q == PH_BACKOFF && req_now < dl_q) begin
					outcome = OC_BACKOFF;
				end else if (budget_out) begin
					outcome = OC_BUDGET;
				end else begin
					accepted = 1'b1;
					cnt_d    = cnt_q + 11'd1;
					phase_d  = PH_WAIT;
					dl_d     = '0;
					dl_set_d = 1'b0;
				end
			end
			OP_FAIL, OP_RESP: begin
				priority if (phase_q != PH_WAIT) begin
					outcome = OC_NO_ATTEMPT;
				end else if (req_cls.code == ST_OK && req_cls.op == OP_FAIL) begin
					outcome = OC_OK_NO_FAIL;
				end else if (req_cls.code == ST_OK) begin
					status_d = ST_OK;
					phase_d  = PH_DONE;
					dl_d     = '0;
					dl_set_d = 1'b0;
				end else if (!req_cls.retry || budget_out) begin
					status_d = req_cls.code;
					phase_d  = PH_FAIL;
					dl_d     = '0;
					dl_set_d = 1'b0;
				end else begin
					status_d = req_cls.code;
					phase_d  = PH_BACKOFF;
					dl_d     = dl_sat;
					dl_set_d = 1'b1;
					bo_d     = bo_next;
				end
			end
			OP_NONE: begin
				outcome = OC_NO_ATTEMPT;
			end
			default: begin
				outcome = OC_NO_ATTEMPT;
			end
		endcase
	end

	always_comb begin
		res.outcome  = outcome;
		res.phase    = phase_d;
		res.attempt  = cnt_d;
		res.target   = accepted ? target_node : 16'd0;
		res.dl_valid = dl_set_d;
		res.status   = status_d;
		res_deadline = dl_set_d ? dl_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			bo_q     <= BACKOFF_BITS'(RST_INIT_BACKOFF);
			dl_q     <= '0;
			dl_set_q <= 1'b0;
			status_q <= ST_NONE;
		end else if (req_take) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			bo_q     <= bo_d;
			dl_q     <= dl_d;
			dl_set_q <= dl_set_d;
			status_q <= status_d;
		end else if (init_wr && cnt_q == '0) begin
			// new initial delay takes effect while no attempt has started
			bo_q <= init_backoff;
		end
	end

`ifndef SYNTHESIS
	a_deadline_only_in_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		dl_set_q |-> phase_q == PH_BACKOFF)
		else $error("deadline set outside backoff");
	a_attempts_never_drop: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q >= $past(cnt_q))
		else $error("attempt count went down");
	a_success_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("left the succeeded phase");
	a_accept_means_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.outcome == OC_ACCEPTED && req_cls.op == OP_BEGIN)
			|=> phase_q == PH_WAIT)
		else $error("accepted begin did not start waiting");
`endif

endmodule
